// ===== rtl/core/trinorm_pkg.sv =====
// Shared types for the triangle face normal pipeline.
// No dependencies; every file in rtl/core except trinorm_if.sv uses this package.
package trinorm_pkg;

  // Pipeline control handed from the top level to a sub-pipeline.
  typedef struct packed {
    logic adv;  // all stages move one place this cycle
    logic vld;  // the word entering the first stage is valid
  } stage_ctl_t;

endpackage

// ===== rtl/core/trinorm_if.sv =====
// Handshake channels of the triangle face normal block: vertex input and normal output.
// No dependencies.
interface trinorm_in_if #(
  parameter int COORD_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] a_x, a_y, a_z;
  logic signed [COORD_WIDTH-1:0] b_x, b_y, b_z;
  logic signed [COORD_WIDTH-1:0] c_x, c_y, c_z;

  modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, input ready);
  modport sink   (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, output ready);
endinterface

interface trinorm_out_if #(
  parameter int NORMAL_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [NORMAL_WIDTH-1:0] normal_x, normal_y, normal_z;
  logic                           degenerate;

  modport source (output valid, normal_x, normal_y, normal_z, degenerate, input ready);
  modport sink   (input valid, normal_x, normal_y, normal_z, degenerate, output ready);
endinterface

// ===== rtl/core/trinorm_isqrt.sv =====
// Pipelined integer square root, one result bit per register stage.
// Depends on trinorm_pkg for the stage control struct.
module trinorm_isqrt #(
  parameter int RW     = 32,
  parameter int SIDE_W = 97
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  trinorm_pkg::stage_ctl_t ctl,
  input  logic [2*RW-1:0]         in_sum,
  input  logic [SIDE_W-1:0]       in_side,
  output logic                    out_vld,
  output logic [RW-1:0]           out_root,
  output logic [SIDE_W-1:0]       out_side
);

  localparam int SW = 2 * RW;

  logic [SW-1:0]     rem_r  [RW];
  logic [RW-1:0]     root_r [RW];
  logic [SIDE_W-1:0] side_r [RW];
  logic [RW-1:0]     vld_r;

  genvar j;
  generate
    for (j = 0; j < RW; j++) begin : g_stage
      localparam int B = RW - 1 - j;
      logic [SW-1:0]     rem_i;
      logic [RW-1:0]     root_i;
      logic [SIDE_W-1:0] side_i;
      logic              vld_i;
      logic [SW:0]       trial;
      logic              take;

      if (j == 0) begin : g_first
        assign rem_i  = in_sum;
        assign root_i = '0;
        assign side_i = in_side;
        assign vld_i  = ctl.vld;
      end else begin : g_next
        assign rem_i  = rem_r[j-1];
        assign root_i = root_r[j-1];
        assign side_i = side_r[j-1];
        assign vld_i  = vld_r[j-1];
      end

      // Try to set root bit B: (R + 2^B)^2 <= S, tested on the running remainder.
      assign trial = ({1'b0, {RW{1'b0}}, root_i} << (B + 1)) + ((SW + 1)'(1) << (2 * B));
      assign take  = {1'b0, rem_i} >= trial;

      always_ff @(posedge clk) begin
        if (ctl.adv) begin
          rem_r[j]  <= take ? (rem_i - trial[SW-1:0]) : rem_i;
          root_r[j] <= take ? (root_i | (RW'(1) << B)) : root_i;
          side_r[j] <= side_i;
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[j] <= 1'b0;
        end else if (ctl.adv) begin
          vld_r[j] <= vld_i;
        end
      end
    end
  endgenerate

  assign out_vld  = vld_r[RW-1];
  assign out_root = root_r[RW-1];
  assign out_side = side_r[RW-1];

endmodule

// ===== rtl/core/trinorm_div.sv =====
// Pipelined restoring divider, three lanes sharing one divisor, one quotient bit per stage.
// Depends on trinorm_pkg for the stage control struct.
module trinorm_div #(
  parameter int RW     = 32,
  parameter int QW     = 15,
  parameter int SIDE_W = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  trinorm_pkg::stage_ctl_t    ctl,
  input  logic [2:0][RW+QW-1:0]      in_num,
  input  logic [RW-1:0]              in_den,
  input  logic [SIDE_W-1:0]          in_side,
  output logic                       out_vld,
  output logic [2:0][QW-1:0]         out_quo,
  output logic [SIDE_W-1:0]          out_side
);

  localparam int DW = RW + QW;

  logic [2:0][DW-1:0] rem_r  [QW];
  logic [2:0][QW-1:0] quo_r  [QW];
  logic [RW-1:0]      den_r  [QW];
  logic [SIDE_W-1:0]  side_r [QW];
  logic [QW-1:0]      vld_r;

  genvar j;
  generate
    for (j = 0; j < QW; j++) begin : g_stage
      localparam int B = QW - 1 - j;
      logic [2:0][DW-1:0] rem_i;
      logic [2:0][QW-1:0] quo_i;
      logic [RW-1:0]      den_i;
      logic [SIDE_W-1:0]  side_i;
      logic               vld_i;
      logic [DW-1:0]      dsh;

      if (j == 0) begin : g_first
        assign rem_i  = in_num;
        assign quo_i  = '0;
        assign den_i  = in_den;
        assign side_i = in_side;
        assign vld_i  = ctl.vld;
      end else begin : g_next
        assign rem_i  = rem_r[j-1];
        assign quo_i  = quo_r[j-1];
        assign den_i  = den_r[j-1];
        assign side_i = side_r[j-1];
        assign vld_i  = vld_r[j-1];
      end

      // Divisor aligned to quotient bit B.
      assign dsh = DW'(den_i) << B;

      always_ff @(posedge clk) begin
        if (ctl.adv) begin
          for (int l = 0; l < 3; l++) begin
            if (rem_i[l] >= dsh) begin
              rem_r[j][l] <= rem_i[l] - dsh;
              quo_r[j][l] <= quo_i[l] | (QW'(1) << B);
            end else begin
              rem_r[j][l] <= rem_i[l];
              quo_r[j][l] <= quo_i[l];
            end
          end
          den_r[j]  <= den_i;
          side_r[j] <= side_i;
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[j] <= 1'b0;
        end else if (ctl.adv) begin
          vld_r[j] <= vld_i;
        end
      end
    end
  endgenerate

  assign out_vld  = vld_r[QW-1];
  assign out_quo  = quo_r[QW-1];
  assign out_side = side_r[QW-1];

endmodule

// ===== rtl/core/triangle_face_normal.sv =====
// Triangle face normal: edges, cross product, length and unit normal in one pipeline.
// Depth: 12 + RW + QW register stages; RW = min(2*COORD_WIDTH+4, 31) + 1 square root stages,
// QW = NORMAL_WIDTH - 1 divider stages; 59 at the defaults.
// Throughput: one triangle per cycle unless stalled; square root and divider retire one bit per stage.
// A stall freezes the whole pipeline; an input skid word keeps in ready registered.
// Reset (synchronous, active low) clears only the valid bits and the skid flag.
module triangle_face_normal #(
  parameter int COORD_WIDTH  = 16,
  parameter int NORMAL_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  trinorm_in_if.sink           in_tri,
  trinorm_out_if.source        out_nrm
);

  localparam int CW    = COORD_WIDTH;
  localparam int NW    = NORMAL_WIDTH;
  localparam int EW    = CW + 1;
  localparam int EMW   = (EW > 30) ? 30 : EW;
  localparam int EKMAX = EW - EMW;
  localparam int EKW   = (EKMAX > 0) ? $clog2(EKMAX + 1) : 1;
  localparam int ESW   = EMW + 1;
  localparam int PW    = 2 * ESW;
  localparam int CRW   = PW + 1;
  localparam int CMW   = CRW - 1;
  localparam int SMW   = (CMW > 31) ? 31 : CMW;
  localparam int MKMAX = CMW - SMW;
  localparam int MKW   = (MKMAX > 0) ? $clog2(MKMAX + 1) : 1;
  localparam int SQW   = 2 * SMW;
  localparam int SW    = 2 * SMW + 2;
  localparam int RW    = SMW + 1;
  localparam int QW    = NW - 1;
  localparam int DW    = RW + QW;
  localparam int QSW   = 3 * SMW + 4;
  localparam int DSW   = 4;
  localparam logic signed [NW-1:0] ONE = NW'(1) << (NW - 2);

  logic adv;
  logic s1_load;

  // Input skid word.
  logic                 skid_v_r;
  logic signed [CW-1:0] skid_a_r [3];
  logic signed [CW-1:0] skid_b_r [3];
  logic signed [CW-1:0] skid_c_r [3];
  logic signed [CW-1:0] in_a [3];
  logic signed [CW-1:0] in_b [3];
  logic signed [CW-1:0] in_c [3];
  logic signed [CW-1:0] src_a [3];
  logic signed [CW-1:0] src_b [3];
  logic signed [CW-1:0] src_c [3];

  // Front pipeline stages.
  logic [9:0]            vld_r;
  logic signed [EW-1:0]  e1_r [3];
  logic signed [EW-1:0]  e2_r [3];
  logic [EW-1:0]         em1_r [3];
  logic [EW-1:0]         em2_r [3];
  logic [2:0]            es1_r, es2_r;
  logic [EKW-1:0]        ksh_nxt;
  logic signed [ESW-1:0] r1_r [3];
  logic signed [ESW-1:0] r2_r [3];
  logic signed [PW-1:0]  prod_r [6];
  logic signed [CRW-1:0] cr_r [3];
  logic [CMW-1:0]        cm6_r [3];
  logic [2:0]            cs6_r;
  logic                  dg6_r;
  logic [CMW-1:0]        cm7_r [3];
  logic [2:0]            cs7_r;
  logic                  dg7_r;
  logic [MKW-1:0]        msh_nxt;
  logic [MKW-1:0]        msh_r;
  logic [SMW-1:0]        sm8_r [3];
  logic [2:0]            cs8_r;
  logic                  dg8_r;
  logic [SQW-1:0]        sq_r [3];
  logic [SMW-1:0]        sm9_r [3];
  logic [2:0]            cs9_r;
  logic                  dg9_r;
  logic [SW-1:0]         sum_r;
  logic [SMW-1:0]        sm10_r [3];
  logic [2:0]            cs10_r;
  logic                  dg10_r;

  // Square root, divider set-up and divider.
  trinorm_pkg::stage_ctl_t sq_ctl, dv_ctl;
  logic                    rt_vld;
  logic [RW-1:0]           rt_root;
  logic [QSW-1:0]          rt_side;
  logic [2:0][DW-1:0]      num_r;
  logic [RW-1:0]           den_r;
  logic [DSW-1:0]          pside_r;
  logic                    pv_r;
  logic                    dv_vld;
  logic [2:0][QW-1:0]      dv_quo;
  logic [DSW-1:0]          dv_side;

  // Output register.
  logic                 out_v_r;
  logic signed [NW-1:0] nrm_nxt [3];
  logic signed [NW-1:0] nrm_r [3];
  logic                 dg_r;

  // The pipeline moves whenever the output register is free or being emptied.
  assign adv           = !out_v_r || out_nrm.ready;
  assign in_tri.ready  = !skid_v_r;
  assign s1_load       = skid_v_r || in_tri.valid;

  assign in_a[0] = in_tri.a_x;
  assign in_a[1] = in_tri.a_y;
  assign in_a[2] = in_tri.a_z;
  assign in_b[0] = in_tri.b_x;
  assign in_b[1] = in_tri.b_y;
  assign in_b[2] = in_tri.b_z;
  assign in_c[0] = in_tri.c_x;
  assign in_c[1] = in_tri.c_y;
  assign in_c[2] = in_tri.c_z;

  // A word held in the skid register goes into the pipeline first.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      src_a[i] = skid_v_r ? skid_a_r[i] : in_a[i];
      src_b[i] = skid_v_r ? skid_b_r[i] : in_b[i];
      src_c[i] = skid_v_r ? skid_c_r[i] : in_c[i];
    end
  end

  // Skid flag: set when a word arrives during a stall, cleared when the pipeline moves.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_v_r <= 1'b0;
    end else if (adv) begin
      skid_v_r <= 1'b0;
    end else if (in_tri.valid && !skid_v_r) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!adv && in_tri.valid && !skid_v_r) begin
      for (int i = 0; i < 3; i++) begin
        skid_a_r[i] <= in_a[i];
        skid_b_r[i] <= in_b[i];
        skid_c_r[i] <= in_c[i];
      end
    end
  end

  // Valid bits of the front stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[8:0], s1_load};
    end
  end

  // Edge prescale shift: smallest shift that brings every edge magnitude below 2^EMW, EMW = min(EW, 30).
  always_comb begin
    logic [EW-1:0] orv;
    orv     = em1_r[0] | em1_r[1] | em1_r[2] | em2_r[0] | em2_r[1] | em2_r[2];
    ksh_nxt = '0;
    for (int k = EKMAX; k >= 0; k--) begin
      if ((orv >> (k + EMW)) == '0) begin
        ksh_nxt = EKW'(k);
      end
    end
  end

  // Cross prescale shift: smallest shift that brings every cross magnitude below 2^SMW, SMW = min(CMW, 31).
  always_comb begin
    logic [CMW-1:0] orv;
    orv     = cm6_r[0] | cm6_r[1] | cm6_r[2];
    msh_nxt = '0;
    for (int m = MKMAX; m >= 0; m--) begin
      if ((orv >> (m + SMW)) == '0) begin
        msh_nxt = MKW'(m);
      end
    end
  end

  // Front datapath: edges, prescale, products, cross, magnitudes, squares and their sum.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        e1_r[i]  <= EW'(src_a[i]) - EW'(src_b[i]);
        e2_r[i]  <= EW'(src_b[i]) - EW'(src_c[i]);
        em1_r[i] <= e1_r[i][EW-1] ? EW'(-e1_r[i]) : EW'(e1_r[i]);
        em2_r[i] <= e2_r[i][EW-1] ? EW'(-e2_r[i]) : EW'(e2_r[i]);
        es1_r[i] <= e1_r[i][EW-1];
        es2_r[i] <= e2_r[i][EW-1];
        r1_r[i]  <= es1_r[i] ? -ESW'(EMW'(em1_r[i] >> ksh_nxt))
                             : ESW'(EMW'(em1_r[i] >> ksh_nxt));
        r2_r[i]  <= es2_r[i] ? -ESW'(EMW'(em2_r[i] >> ksh_nxt))
                             : ESW'(EMW'(em2_r[i] >> ksh_nxt));
        cr_r[i]  <= CRW'(prod_r[2*i]) - CRW'(prod_r[2*i+1]);
        cm6_r[i] <= cr_r[i][CRW-1] ? CMW'(-cr_r[i]) : CMW'(cr_r[i]);
        cs6_r[i] <= cr_r[i][CRW-1];
        cm7_r[i] <= cm6_r[i];
        sm8_r[i] <= SMW'(cm7_r[i] >> msh_r);
        sq_r[i]  <= SQW'(sm8_r[i]) * SQW'(sm8_r[i]);
        sm9_r[i] <= sm8_r[i];
        sm10_r[i] <= sm9_r[i];
      end
      prod_r[0] <= PW'(r1_r[1]) * PW'(r2_r[2]);
      prod_r[1] <= PW'(r1_r[2]) * PW'(r2_r[1]);
      prod_r[2] <= PW'(r1_r[2]) * PW'(r2_r[0]);
      prod_r[3] <= PW'(r1_r[0]) * PW'(r2_r[2]);
      prod_r[4] <= PW'(r1_r[0]) * PW'(r2_r[1]);
      prod_r[5] <= PW'(r1_r[1]) * PW'(r2_r[0]);
      dg6_r  <= (cr_r[0] == '0) && (cr_r[1] == '0) && (cr_r[2] == '0);
      cs7_r  <= cs6_r;
      dg7_r  <= dg6_r;
      msh_r  <= msh_nxt;
      cs8_r  <= cs7_r;
      dg8_r  <= dg7_r;
      cs9_r  <= cs8_r;
      dg9_r  <= dg8_r;
      sum_r  <= SW'(sq_r[0]) + SW'(sq_r[1]) + SW'(sq_r[2]);
      cs10_r <= cs9_r;
      dg10_r <= dg9_r;
    end
  end

  // Length of the prescaled cross product.
  assign sq_ctl.adv = adv;
  assign sq_ctl.vld = vld_r[9];

  trinorm_isqrt #(
    .RW     (RW),
    .SIDE_W (QSW)
  ) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (sq_ctl),
    .in_sum   (sum_r),
    .in_side  ({sm10_r[2], sm10_r[1], sm10_r[0], cs10_r, dg10_r}),
    .out_vld  (rt_vld),
    .out_root (rt_root),
    .out_side (rt_side)
  );

  // Dividend: magnitude scaled to Q1.(NW-2) plus half the length for rounding.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        num_r[i] <= (DW'(rt_side[4 + i*SMW +: SMW]) << (QW - 1)) + DW'(rt_root >> 1);
      end
      den_r   <= rt_root;
      pside_r <= rt_side[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else if (adv) begin
      pv_r <= rt_vld;
    end
  end

  assign dv_ctl.adv = adv;
  assign dv_ctl.vld = pv_r;

  trinorm_div #(
    .RW     (RW),
    .QW     (QW),
    .SIDE_W (DSW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (dv_ctl),
    .in_num   (num_r),
    .in_den   (den_r),
    .in_side  (pside_r),
    .out_vld  (dv_vld),
    .out_quo  (dv_quo),
    .out_side (dv_side)
  );

  // Restore signs, or give (0, 0, ONE) for a degenerate triangle.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nrm_nxt[i] = dv_side[1+i] ? (NW'(0) - {1'b0, dv_quo[i]}) : {1'b0, dv_quo[i]};
    end
    if (dv_side[0]) begin
      nrm_nxt[0] = '0;
      nrm_nxt[1] = '0;
      nrm_nxt[2] = ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        nrm_r[i] <= nrm_nxt[i];
      end
      dg_r <= dv_side[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= dv_vld;
    end
  end

  assign out_nrm.valid      = out_v_r;
  assign out_nrm.normal_x   = nrm_r[0];
  assign out_nrm.normal_y   = nrm_r[1];
  assign out_nrm.normal_z   = nrm_r[2];
  assign out_nrm.degenerate = dg_r;

  // A word parked in the skid register enters the first stage on the next move.
  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    adv && skid_v_r |=> vld_r[0])
    else $error("skid word not taken into the pipeline");

  // A stall freezes the front valid bits.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r))
    else $error("front pipeline moved during a stall");

  // A degenerate result is always the fixed normal (0, 0, ONE).
  a_degen_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && dg_r |-> nrm_r[0] == '0 && nrm_r[1] == '0 && nrm_r[2] == ONE)
    else $error("degenerate result without the fixed normal");

  // Every component of a unit normal lies within [-ONE, ONE].
  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> nrm_r[0] <= ONE && nrm_r[0] >= -ONE && nrm_r[1] <= ONE
      && nrm_r[1] >= -ONE && nrm_r[2] <= ONE && nrm_r[2] >= -ONE)
    else $error("normal component out of range");

endmodule
